/* hdl/htcc_pkg.sv */
// Shared types, constants and helpers for the Hamming threshold confusion counter.
`default_nettype none

package htcc_pkg;

    // Default structure of the lane array
    localparam int LANES_DEF        = 4;
    localparam int ELEMENT_BITS_DEF = 16;

    // Fixed field widths
    localparam int CODE_BITS  = 64;
    localparam int ID_BITS    = 32;
    localparam int VALID_BITS = 3;
    localparam int DIST_BITS  = 9;
    localparam int COUNT_BITS = 40;

    // Operation codes
    localparam logic OP_COMPARE = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [DIST_BITS-1:0]  dist_t;

    // Input request
    typedef struct packed {
        logic                  op;
        logic [CODE_BITS-1:0]  codes_a;
        logic [CODE_BITS-1:0]  codes_b;
        logic [VALID_BITS-1:0] lanes_valid;
        logic                  last_chunk;
        logic [ID_BITS-1:0]    entity_a;
        logic [ID_BITS-1:0]    entity_b;
    } in_req_t;

    // Result
    typedef struct packed {
        dist_t  distance;
        logic   near_pair;
        logic   same_entity;
        count_t true_pos;
        count_t true_neg;
        count_t false_pos;
        count_t false_neg;
    } out_res_t;

    // Control carried alongside the registered lane flags
    typedef struct packed {
        logic op;
        logic last_chunk;
        logic same_entity;
    } stage_ctrl_t;

    // Saturating increment of a confusion counter
    function automatic count_t sat_inc(input count_t c);
        count_t r;
        r = (&c) ? c : c + count_t'(1);
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/hamming_threshold_confusion_counter_core.sv */
// Top level of the Hamming threshold confusion counter: lane array, request stage and merge.
`default_nettype none

// Takes one request per clock; while a result waits for the consumer it keeps
// taking middle chunks and clears. A request passes two registers: the lane
// compare flags (with the entity id compare) and the merge stage's output
// register, so a result is offered on m_valid once its last chunk has moved
// from the flag register into the output register. The merge stage's distance
// and counter update is combinational, which sets the rate of one chunk per
// clock. Middle chunks and clears never wait for the result side; only a last
// chunk stalls when a previous result has not yet been taken. Write max_distance
// only while the block is idle. No clearing pass follows reset.
module hamming_threshold_confusion_counter_core #(
    parameter int LANES        = htcc_pkg::LANES_DEF,
    parameter int ELEMENT_BITS = htcc_pkg::ELEMENT_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wen,
    input  wire htcc_pkg::dist_t     cfg_wdata,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire htcc_pkg::in_req_t   s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output htcc_pkg::out_res_t       m_data
);

    logic                  accept;
    logic                  s1_advance;
    logic [LANES-1:0]      lane_diff;
    logic                  s1_valid_reg, s1_valid_next;
    htcc_pkg::stage_ctrl_t s1_ctrl_reg, s1_ctrl_next;
    htcc_pkg::dist_t       max_distance_reg, max_distance_next;

    // Request handshake
    assign s_ready = !s1_valid_reg || s1_advance;
    assign accept  = s_valid && s_ready;

    // Lane array
    generate
        for (genvar i = 0; i < LANES; i++) begin : g_lane
            htcc_lane #(
                .ELEMENT_BITS(ELEMENT_BITS),
                .LANE_INDEX  (i)
            ) u_lane (
                .aclk       (aclk),
                .load       (accept),
                .codes_a    (s_data.codes_a),
                .codes_b    (s_data.codes_b),
                .lanes_valid(s_data.lanes_valid),
                .diff_reg   (lane_diff[i])
            );
        end
    endgenerate

    // Request stage control
    always_comb begin
        s1_valid_next = s1_valid_reg && !s1_advance;
        s1_ctrl_next  = s1_ctrl_reg;
        if (accept) begin
            s1_valid_next            = 1'b1;
            s1_ctrl_next.op          = s_data.op;
            s1_ctrl_next.last_chunk  = s_data.last_chunk;
            s1_ctrl_next.same_entity = (s_data.entity_a == s_data.entity_b);
        end
    end

    // Threshold register
    assign max_distance_next = cfg_wen ? cfg_wdata : max_distance_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg     <= 1'b0;
            max_distance_reg <= '0;
        end else begin
            s1_valid_reg     <= s1_valid_next;
            max_distance_reg <= max_distance_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_ctrl_reg <= s1_ctrl_next;
    end

    // Merge stage
    htcc_merge #(
        .LANES(LANES)
    ) u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s1_valid    (s1_valid_reg),
        .s1_ctrl     (s1_ctrl_reg),
        .lane_diff   (lane_diff),
        .max_distance(max_distance_reg),
        .s1_advance  (s1_advance),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

`default_nettype wire

/* hdl/htcc_lane.sv */
// One compare lane: checks whether its element of A and B differ.
`default_nettype none

module htcc_lane #(
    parameter int ELEMENT_BITS = htcc_pkg::ELEMENT_BITS_DEF,
    parameter int LANE_INDEX   = 0
) (
    input  wire logic                            aclk,
    input  wire logic                            load,
    input  wire logic [htcc_pkg::CODE_BITS-1:0]  codes_a,
    input  wire logic [htcc_pkg::CODE_BITS-1:0]  codes_b,
    input  wire logic [htcc_pkg::VALID_BITS-1:0] lanes_valid,
    output logic                                 diff_reg
);

    localparam int LO = LANE_INDEX * ELEMENT_BITS;

    logic diff_next;
    logic lane_on;

    // Lane takes part only below the request's lane count
    assign lane_on = (int'(lanes_valid) > LANE_INDEX);

    generate
        if (LO >= htcc_pkg::CODE_BITS) begin : g_outside
            // Lane lies beyond the code word: both sides read as zero
            assign diff_next = 1'b0;
        end else begin : g_inside
            logic [htcc_pkg::CODE_BITS-1:0] a_sh;
            logic [htcc_pkg::CODE_BITS-1:0] b_sh;
            // Bits past the top of the word shift in as zero
            assign a_sh      = codes_a >> LO;
            assign b_sh      = codes_b >> LO;
            assign diff_next = lane_on && (a_sh[ELEMENT_BITS-1:0] != b_sh[ELEMENT_BITS-1:0]);
        end
    endgenerate

    // Flag register
    always_ff @(posedge aclk) begin
        if (load) begin
            diff_reg <= diff_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/htcc_merge.sv */
// Merge stage: counts lane flags, keeps the running distance and the confusion counters.
`default_nettype none

module htcc_merge #(
    parameter int LANES = htcc_pkg::LANES_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s1_valid,
    input  wire htcc_pkg::stage_ctrl_t s1_ctrl,
    input  wire logic [LANES-1:0]      lane_diff,
    input  wire htcc_pkg::dist_t       max_distance,
    output logic                       s1_advance,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output htcc_pkg::out_res_t         m_data
);

    localparam int CNT_W = $clog2(LANES + 1);

    logic [CNT_W-1:0]            chunk_count;
    logic [htcc_pkg::DIST_BITS:0] dist_sum;
    htcc_pkg::dist_t             dist_val;
    logic                        near_pair;
    logic                        gives_result;

    htcc_pkg::dist_t    partial_reg, partial_next;
    htcc_pkg::count_t   tp_reg, tp_next;
    htcc_pkg::count_t   tn_reg, tn_next;
    htcc_pkg::count_t   fp_reg, fp_next;
    htcc_pkg::count_t   fn_reg, fn_next;
    logic               m_valid_reg, m_valid_next;
    htcc_pkg::out_res_t m_data_reg, m_data_next;

    // Number of differing lanes in this chunk
    always_comb begin
        chunk_count = '0;
        for (int i = 0; i < LANES; i++) begin
            chunk_count = chunk_count + CNT_W'(lane_diff[i]);
        end
    end

    // Running distance, saturating at all ones
    assign dist_sum = {1'b0, partial_reg} + (htcc_pkg::DIST_BITS + 1)'(chunk_count);
    assign dist_val = dist_sum[htcc_pkg::DIST_BITS] ? '1 : dist_sum[htcc_pkg::DIST_BITS-1:0];
    assign near_pair = (dist_val <= max_distance);

    // Only the last chunk of a compare yields a result; others never wait on the output
    assign gives_result = (s1_ctrl.op == htcc_pkg::OP_COMPARE) && s1_ctrl.last_chunk;
    assign s1_advance   = s1_valid && (!gives_result || !m_valid_reg || m_ready);

    // State update
    always_comb begin
        partial_next = partial_reg;
        tp_next      = tp_reg;
        tn_next      = tn_reg;
        fp_next      = fp_reg;
        fn_next      = fn_reg;
        if (s1_advance) begin
            if (s1_ctrl.op == htcc_pkg::OP_CLEAR) begin
                tp_next = '0;
                tn_next = '0;
                fp_next = '0;
                fn_next = '0;
            end else if (s1_ctrl.last_chunk) begin
                partial_next = '0;
                if (near_pair && s1_ctrl.same_entity) begin
                    tp_next = htcc_pkg::sat_inc(tp_reg);
                end else if (!near_pair && !s1_ctrl.same_entity) begin
                    tn_next = htcc_pkg::sat_inc(tn_reg);
                end else if (near_pair) begin
                    fp_next = htcc_pkg::sat_inc(fp_reg);
                end else begin
                    fn_next = htcc_pkg::sat_inc(fn_reg);
                end
            end else begin
                partial_next = dist_val;
            end
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (s1_advance && gives_result) begin
            m_valid_next            = 1'b1;
            m_data_next.distance    = dist_val;
            m_data_next.near_pair   = near_pair;
            m_data_next.same_entity = s1_ctrl.same_entity;
            m_data_next.true_pos    = tp_next;
            m_data_next.true_neg    = tn_next;
            m_data_next.false_pos   = fp_next;
            m_data_next.false_neg   = fn_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= '0;
            tp_reg      <= '0;
            tn_reg      <= '0;
            fp_reg      <= '0;
            fn_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            partial_reg <= partial_next;
            tp_reg      <= tp_next;
            tn_reg      <= tn_next;
            fp_reg      <= fp_next;
            fn_reg      <= fn_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A clear leaves all four counters at zero
    a_clear_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_advance && (s1_ctrl.op == htcc_pkg::OP_CLEAR)
        |=> (tp_reg == '0) && (tn_reg == '0) && (fp_reg == '0) && (fn_reg == '0))
        else $error("counters not cleared");

    // Running distance restarts once a pair is finished
    a_partial_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_advance && gives_result |=> partial_reg == '0)
        else $error("partial distance not restarted");

    // A shown result agrees with the threshold
    a_close_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_data_reg.near_pair == (m_data_reg.distance <= max_distance))
        else $error("near_pair inconsistent with distance");

    // A held result is never overwritten
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !(s1_advance && gives_result))
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

/* sim/htcc_checker.sv */
// Scoreboard for the Hamming threshold confusion counter: predicts each verdict and checks it.
`timescale 1ns / 100ps

module htcc_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wen,
    input  htcc_pkg::dist_t    cfg_wdata,
    input  logic               s_valid,
    input  logic               s_ready,
    input  htcc_pkg::in_req_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  htcc_pkg::out_res_t m_data,
    output int                 n_fail,
    output int                 n_waiting,
    output int                 n_requests,
    output int                 n_checked
);

    localparam int LANE_CNT = htcc_pkg::LANES_DEF;
    localparam int ELEM_W   = htcc_pkg::ELEMENT_BITS_DEF;

    // Shadow copy of the block's register and state
    htcc_pkg::dist_t    close_limit;
    htcc_pkg::dist_t    run_dist;
    htcc_pkg::count_t   tp_cnt;
    htcc_pkg::count_t   tn_cnt;
    htcc_pkg::count_t   fp_cnt;
    htcc_pkg::count_t   fn_cnt;
    htcc_pkg::out_res_t pending_verdicts[$];

    // Folds one request into the shadow state; returns 1 when a verdict is due
    function automatic bit score_chunk(input htcc_pkg::in_req_t r,
                                       output htcc_pkg::out_res_t res);
        int              lanes;
        htcc_pkg::dist_t d;
        logic            near_pair;
        logic            same;
        res = '0;
        if (r.op == htcc_pkg::OP_CLEAR) begin
            tp_cnt = '0;
            tn_cnt = '0;
            fp_cnt = '0;
            fn_cnt = '0;
            return 1'b0;
        end
        // lane counts above the array width saturate to the width
        lanes = (int'(r.lanes_valid) > LANE_CNT) ? LANE_CNT : int'(r.lanes_valid);
        d = run_dist;
        for (int i = 0; i < lanes; i++) begin
            // a lane beyond the code word reads zero on both sides, so never differs
            if (i * ELEM_W < htcc_pkg::CODE_BITS && ~&d &&
                r.codes_a[i*ELEM_W +: ELEM_W] != r.codes_b[i*ELEM_W +: ELEM_W])
                d = d + 1'b1;
        end
        if (!r.last_chunk) begin
            run_dist = d;
            return 1'b0;
        end
        run_dist  = '0;
        near_pair = (d <= close_limit);
        same      = (r.entity_a == r.entity_b);
        // exactly one counter moves, each sticks at all-ones
        if (near_pair && same) begin
            if (~&tp_cnt) tp_cnt = tp_cnt + 1'b1;
        end else if (!near_pair && !same) begin
            if (~&tn_cnt) tn_cnt = tn_cnt + 1'b1;
        end else if (near_pair) begin
            if (~&fp_cnt) fp_cnt = fp_cnt + 1'b1;
        end else begin
            if (~&fn_cnt) fn_cnt = fn_cnt + 1'b1;
        end
        res.distance    = d;
        res.near_pair   = near_pair;
        res.same_entity = same;
        res.true_pos    = tp_cnt;
        res.true_neg    = tn_cnt;
        res.false_pos   = fp_cnt;
        res.false_neg   = fn_cnt;
        return 1'b1;
    endfunction

    // Watch both channels and the limit register at every edge
    always @(posedge aclk) begin : watch
        htcc_pkg::out_res_t want;
        string              bad;
        if (!aresetn) begin
            close_limit = '0;
            run_dist    = '0;
            tp_cnt      = '0;
            tn_cnt      = '0;
            fp_cnt      = '0;
            fn_cnt      = '0;
            pending_verdicts.delete();
        end else begin
            if (cfg_wen)
                close_limit = cfg_wdata;
            if (s_valid && s_ready) begin
                n_requests++;
                if (score_chunk(s_data, want))
                    pending_verdicts.insert(pending_verdicts.size(), want);
            end
            if (m_valid && m_ready) begin
                if (pending_verdicts.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("mismatch %0d: result with none expected, d=%0d tp=%0d",
                                 n_fail, m_data.distance, m_data.true_pos);
                end else begin
                    want = pending_verdicts.pop_front();
                    n_checked++;
                    bad = "";
                    if (m_data.distance !== want.distance)       bad = {bad, " distance"};
                    if (m_data.near_pair !== want.near_pair)     bad = {bad, " near_pair"};
                    if (m_data.same_entity !== want.same_entity) bad = {bad, " same_entity"};
                    if (m_data.true_pos !== want.true_pos)       bad = {bad, " true_pos"};
                    if (m_data.true_neg !== want.true_neg)       bad = {bad, " true_neg"};
                    if (m_data.false_pos !== want.false_pos)     bad = {bad, " false_pos"};
                    if (m_data.false_neg !== want.false_neg)     bad = {bad, " false_neg"};
                    if (bad != "") begin
                        n_fail++;
                        if (n_fail <= 10) begin
                            $display("mismatch %0d in%s at result %0d", n_fail, bad, n_checked);
                            $display("  expected d=%0d close=%0b same=%0b tp=%0d tn=%0d fp=%0d fn=%0d",
                                     want.distance, want.near_pair, want.same_entity,
                                     want.true_pos, want.true_neg, want.false_pos,
                                     want.false_neg);
                            $display("  actual   d=%0d close=%0b same=%0b tp=%0d tn=%0d fp=%0d fn=%0d",
                                     m_data.distance, m_data.near_pair, m_data.same_entity,
                                     m_data.true_pos, m_data.true_neg, m_data.false_pos,
                                     m_data.false_neg);
                        end
                    end
                end
            end
        end
        n_waiting = pending_verdicts.size();
    end

endmodule

/* sim/tb_top.sv */
// Testbench top: clock, reset, request and result traffic, limit writes and the verdict.
`timescale 1ns / 100ps

module tb_top;

    localparam int ELEM_W     = htcc_pkg::ELEMENT_BITS_DEF;
    localparam int LANE_CNT   = htcc_pkg::LANES_DEF;
    localparam int CODE_W     = htcc_pkg::CODE_BITS;
    localparam int VAL_W      = htcc_pkg::VALID_BITS;
    localparam int ID_W       = htcc_pkg::ID_BITS;
    localparam int STALL_MAX  = 4000;
    localparam int HOLD_LONG  = 300;
    localparam int PHASE_REQS = 130;
    localparam int SAT_CHUNKS = 135;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_wen;
    htcc_pkg::dist_t    cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    htcc_pkg::in_req_t  s_data;
    logic               m_valid;
    logic               m_ready;
    htcc_pkg::out_res_t m_data;

    int n_fail;
    int n_waiting;
    int n_requests;
    int n_checked;
    bit idle_on      = 1'b1;
    int stall_cycles = 0;

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    hamming_threshold_confusion_counter_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    htcc_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .n_fail     (n_fail),
        .n_waiting  (n_waiting),
        .n_requests (n_requests),
        .n_checked  (n_checked)
    );

    // Alternate stretches with and without idle gaps; flipped off the falling edge
    initial begin
        forever begin
            repeat ($urandom_range(40, 300)) @(negedge aclk);
            idle_on = !idle_on;
        end
    end

    function automatic int draw_gap();
        return idle_on ? $urandom_range(0, 10) : 0;
    endfunction

    // Watchdog: no request and no result for too long ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_MAX) begin
                $display("no progress for %0d cycles", STALL_MAX);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Result side: random back-pressure, plus two long hold-offs to fill the block
    initial begin : sink
        int taken;
        int gap;
        taken = 0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            gap = (taken == 30 || taken == 200) ? HOLD_LONG : draw_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
        end
    end

    function automatic htcc_pkg::in_req_t mk_req(input logic op, input logic [CODE_W-1:0] a,
                                                 input logic [CODE_W-1:0] b,
                                                 input logic [VAL_W-1:0] lanes,
                                                 input logic last, input logic [ID_W-1:0] ea,
                                                 input logic [ID_W-1:0] eb);
        htcc_pkg::in_req_t r;
        r.op          = op;
        r.codes_a     = a;
        r.codes_b     = b;
        r.lanes_valid = lanes;
        r.last_chunk  = last;
        r.entity_a    = ea;
        r.entity_b    = eb;
        return r;
    endfunction

    // Random compare chunk; each lane of B differs from A with the given percentage
    function automatic htcc_pkg::in_req_t make_chunk(input bit is_last, input int diff_pct);
        htcc_pkg::in_req_t r;
        logic [ELEM_W-1:0] flip;
        r.op      = htcc_pkg::OP_COMPARE;
        r.codes_a = {$urandom, $urandom};
        r.codes_b = r.codes_a;
        for (int l = 0; l < LANE_CNT; l++) begin
            if ($urandom_range(0, 99) < diff_pct) begin
                flip = ELEM_W'($urandom_range(1, (1 << ELEM_W) - 1));
                r.codes_b[l*ELEM_W +: ELEM_W] ^= flip;
            end
        end
        r.lanes_valid = VAL_W'(($urandom_range(0, 4) != 0) ? LANE_CNT : $urandom_range(0, 7));
        r.last_chunk  = is_last;
        r.entity_a    = $urandom;
        r.entity_b    = ($urandom_range(0, 1) != 0) ? r.entity_a : $urandom;
        return r;
    endfunction

    function automatic htcc_pkg::in_req_t make_clear();
        return mk_req(htcc_pkg::OP_CLEAR, {$urandom, $urandom}, {$urandom, $urandom},
                      VAL_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                      $urandom, $urandom);
    endfunction

    // Offer one request; valid stays up across back-to-back requests
    task automatic send_req(input htcc_pkg::in_req_t r);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data  <= r;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Let every expected verdict arrive and the pipeline settle
    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (n_waiting != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_limit(input htcc_pkg::dist_t v);
        cfg_wdata <= v;
        cfg_wen   <= 1'b1;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
    endtask

    // Mostly short pairs with random content, clears now and then, some mid-pair
    task automatic random_phase(input int n_items);
        int sent;
        int n_chunks;
        int pct;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 4) begin
                send_req(make_clear());
                sent++;
            end else begin
                n_chunks = $urandom_range(1, 6);
                pct      = $urandom_range(0, 100);
                for (int c = 0; c < n_chunks; c++) begin
                    if ($urandom_range(0, 99) < 2) begin
                        send_req(make_clear());
                        sent++;
                    end
                    send_req(make_chunk(c == n_chunks - 1, pct));
                    sent++;
                end
            end
        end
    endtask

    initial begin : stimulus
        htcc_pkg::dist_t   limits [7];
        htcc_pkg::in_req_t req;
        cfg_wen   <= 1'b0;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        aresetn   <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn   <= 1'b1;

        // Directed requests, limit of two
        write_limit(9'd2);
        // identical codes, same record
        send_req(mk_req(htcc_pkg::OP_COMPARE, 64'h0, 64'h0, 3'd4, 1'b1, 32'h0, 32'h0));
        // every lane differs at the field extremes
        send_req(mk_req(htcc_pkg::OP_COMPARE, 64'h0, '1, 3'd4, 1'b1, 32'h0, '1));
        // no lanes compared
        send_req(mk_req(htcc_pkg::OP_COMPARE, '1, 64'h0, 3'd0, 1'b1, '1, '1));
        // lane counts past the array width fall back to four
        send_req(mk_req(htcc_pkg::OP_COMPARE, 64'h0123_4567_89AB_CDEF,
                        64'hFEDC_BA98_7654_3210, 3'd5, 1'b1, 32'h1234, 32'h1235));
        send_req(mk_req(htcc_pkg::OP_COMPARE, 64'h0123_4567_89AB_CDEF,
                        64'hFEDC_BA98_7654_3210, 3'd7, 1'b1, 32'hA5A5_0000, 32'hA5A5_0000));
        // distance carried over from a middle chunk, one above the limit
        send_req(mk_req(htcc_pkg::OP_COMPARE, 64'h0, 64'h0000_0000_0001_8000, 3'd2, 1'b0,
                        32'h1, 32'h2));
        send_req(mk_req(htcc_pkg::OP_COMPARE, 64'h5555_5555_5555_5555,
                        64'h5555_5555_5555_5554, 3'd1, 1'b1, 32'd7, 32'd7));
        // distance exactly at the limit still counts as close
        send_req(mk_req(htcc_pkg::OP_COMPARE, 64'hFFFF_0000_FFFF_0000,
                        64'h0000_0000_0000_FFFF, 3'd3, 1'b1, 32'd1, 32'd2));
        // only the top lane differs: hidden with three lanes, counted with four
        send_req(mk_req(htcc_pkg::OP_COMPARE, 64'h8000_0000_0000_0000, 64'h0, 3'd3, 1'b1,
                        32'd9, 32'd9));
        send_req(mk_req(htcc_pkg::OP_COMPARE, 64'h8000_0000_0000_0000, 64'h0, 3'd4, 1'b1,
                        32'd9, 32'd9));
        // a clear inside a pair keeps the running distance
        send_req(mk_req(htcc_pkg::OP_COMPARE, 64'h0, 64'h1, 3'd1, 1'b0, 32'h0, 32'h0));
        send_req(mk_req(htcc_pkg::OP_CLEAR, '1, '1, 3'd7, 1'b1, '1, 32'h0));
        send_req(mk_req(htcc_pkg::OP_COMPARE, '1, '1, 3'd4, 1'b1, 32'h8000_0000,
                        32'h0000_0001));
        // a clear flagged as last gives no verdict
        send_req(mk_req(htcc_pkg::OP_CLEAR, 64'h0, 64'h0, 3'd0, 1'b1, 32'h0, 32'h0));
        send_req(mk_req(htcc_pkg::OP_COMPARE, 64'hFFFF, 64'h0, 3'd1, 1'b1, '1,
                        32'h7FFF_FFFF));
        drain();

        // Random phases over a range of limits, extremes included
        limits    = '{9'd0, 9'd256, 9'd4, 9'd1, 9'd0, 9'd12, 9'd0};
        limits[4] = htcc_pkg::dist_t'($urandom_range(2, 20));
        foreach (limits[p]) begin
            write_limit(limits[p]);
            // one long pair that drives the running distance into saturation
            if (limits[p] == 9'd256) begin
                for (int c = 0; c < SAT_CHUNKS; c++) begin
                    req             = make_chunk(c == SAT_CHUNKS - 1, 100);
                    req.lanes_valid = VAL_W'(LANE_CNT);
                    send_req(req);
                end
            end
            random_phase(PHASE_REQS);
            drain();
        end

        repeat (8) @(posedge aclk);
        $display("run summary: %0d requests, %0d verdicts checked, %0d mismatches",
                 n_requests, n_checked, n_fail);
        $display("limits 0 to 256, lane counts 0 to 7, clears mid-pair, saturated distance, "
                 , "long output hold-offs");
        if (n_fail == 0 && n_waiting == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
